>>> rtl/bounded_shifting_array_list_top_defines.svh
// Assertion macros for the bounded shifting array list checker.
`ifndef BOUNDED_SHIFTING_ARRAY_LIST_TOP_DEFINES_SVH
`define BOUNDED_SHIFTING_ARRAY_LIST_TOP_DEFINES_SVH

// Clocked assertion with asynchronous active-low reset disable.
`define BSAL_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Same, with a caller-supplied message.
`define BSAL_ASSERT_MSG(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

>>> rtl/bsal_pkg.sv
// Shared types and codes for the bounded shifting array list.
package bsal_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned PosW  = 7;
  localparam int unsigned CountW = 7;

  typedef enum logic [2:0] {
    CMD_READ   = 3'd0,
    CMD_WRITE  = 3'd1,
    CMD_PUSH   = 3'd2,
    CMD_POP    = 3'd3,
    CMD_INSERT = 3'd4,
    CMD_ERASE  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // Broadcast to every cell; all flags are qualified by an accepted transaction.
  typedef struct packed {
    logic rd;
    logic wr_pos;
    logic append;
    logic insert;
    logic erase;
  } cell_ctrl_t;

endpackage

>>> rtl/bsal_cell.sv
// One storage cell of the list: holds a word and shifts with its neighbors.
module bsal_cell #(
  parameter int unsigned IdxW = 7,
  parameter int unsigned Idx  = 0
) (
  input  logic                             clk_i,
  input  bsal_pkg::cell_ctrl_t             ctrl_i,
  input  logic [IdxW-1:0]                  pos_i,
  input  logic [IdxW-1:0]                  cnt_i,
  input  logic signed [bsal_pkg::DataW-1:0] value_i,
  input  logic signed [bsal_pkg::DataW-1:0] left_i,
  input  logic signed [bsal_pkg::DataW-1:0] right_i,
  output logic signed [bsal_pkg::DataW-1:0] word_o,
  output logic signed [bsal_pkg::DataW-1:0] rd_o
);

  logic signed [bsal_pkg::DataW-1:0] word_q, word_d;
  logic [IdxW-1:0] idx;
  logic hit, at_tail;

  assign idx     = IdxW'(Idx);
  assign hit     = (idx == pos_i);
  assign at_tail = (idx == cnt_i);

  always_comb begin
    word_d = word_q;
    if ((ctrl_i.wr_pos && hit) || (ctrl_i.append && at_tail) ||
        (ctrl_i.insert && hit)) begin
      word_d = value_i;
    end else if (ctrl_i.insert && (idx > pos_i)) begin
      word_d = left_i;
    end else if (ctrl_i.erase && (idx >= pos_i)) begin
      word_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;
  assign rd_o   = (ctrl_i.rd && hit) ? word_q : '0;

endmodule

>>> rtl/bounded_shifting_array_list_top.sv
// Bounded shifting array list: top level with command decode, count and result register.
// One command is accepted per cycle and its result appears in the output register on the
// next cycle. Insert and erase need no extra states or passes either:
// the row of CAPACITY storage cells moves all entries by one place at once, and the read
// port is an AND-OR gather over the cells. A new command is held off only while a result
// sits in the output register and the downstream side stalls. Entries start undefined and
// the count resets to zero; no clearing pass is needed after reset.
module bounded_shifting_array_list_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [2:0]                          cmd_i,
  input  logic [bsal_pkg::PosW-1:0]           position_i,
  input  logic signed [bsal_pkg::DataW-1:0]   value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [bsal_pkg::DataW-1:0]   read_data_o,
  output logic [1:0]                          status_o,
  output logic [bsal_pkg::CountW-1:0]         count_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (CntW > bsal_pkg::PosW) ? CntW : bsal_pkg::PosW;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CmpW-1:0] pos_ext, cnt_ext, cnt_next_ext;
  logic            accept, in_range, ins_pos_ok, full, empty;
  bsal_pkg::cell_ctrl_t ctrl;
  bsal_pkg::status_e    status;

  logic signed [bsal_pkg::DataW-1:0] word [CAPACITY];
  logic signed [bsal_pkg::DataW-1:0] rd   [CAPACITY];
  logic signed [bsal_pkg::DataW-1:0] rd_any;

  logic                              out_valid_q;
  logic signed [bsal_pkg::DataW-1:0] read_data_q;
  logic [1:0]                        status_q;
  logic [bsal_pkg::CountW-1:0]       count_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign pos_ext    = CmpW'(position_i);
  assign cnt_ext    = CmpW'(cnt_q);
  assign in_range   = (pos_ext < cnt_ext);
  assign ins_pos_ok = (pos_ext <= cnt_ext);
  assign full       = (cnt_ext == CmpW'(CAPACITY));
  assign empty      = (cnt_q == '0);

  always_comb begin
    ctrl   = '0;
    status = bsal_pkg::ST_OK;
    cnt_d  = cnt_q;
    case (bsal_pkg::cmd_e'(cmd_i))
      bsal_pkg::CMD_READ: begin
        if (in_range) ctrl.rd = 1'b1;
        else          status  = bsal_pkg::ST_RANGE;
      end
      bsal_pkg::CMD_WRITE: begin
        if (in_range) ctrl.wr_pos = 1'b1;
        else          status      = bsal_pkg::ST_RANGE;
      end
      bsal_pkg::CMD_PUSH: begin
        if (full) begin
          status = bsal_pkg::ST_FULL;
        end else begin
          ctrl.append = 1'b1;
          cnt_d       = cnt_q + 1'b1;
        end
      end
      bsal_pkg::CMD_POP: begin
        if (empty) status = bsal_pkg::ST_EMPTY;
        else       cnt_d  = cnt_q - 1'b1;
      end
      bsal_pkg::CMD_INSERT: begin
        if (!ins_pos_ok) begin
          status = bsal_pkg::ST_RANGE;
        end else if (full) begin
          status = bsal_pkg::ST_FULL;
        end else begin
          ctrl.insert = 1'b1;
          cnt_d       = cnt_q + 1'b1;
        end
      end
      bsal_pkg::CMD_ERASE: begin
        if (!in_range) begin
          status = bsal_pkg::ST_RANGE;
        end else begin
          ctrl.erase = 1'b1;
          cnt_d      = cnt_q - 1'b1;
        end
      end
      default: ;
    endcase
    if (!accept) begin
      ctrl  = '0;
      cnt_d = cnt_q;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [bsal_pkg::DataW-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = word[i];
    end else begin : g_mid_l
      assign left = word[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = word[i];
    end else begin : g_mid_r
      assign right = word[i+1];
    end
    bsal_cell #(
      .IdxW (CmpW),
      .Idx  (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .pos_i   (pos_ext),
      .cnt_i   (cnt_ext),
      .value_i (value_i),
      .left_i  (left),
      .right_i (right),
      .word_o  (word[i]),
      .rd_o    (rd[i])
    );
  end

  always_comb begin
    rd_any = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_any = rd_any | rd[i];
    end
  end

  assign cnt_next_ext = CmpW'(cnt_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      read_data_q <= rd_any;
      status_q    <= status;
      count_q     <= cnt_next_ext[bsal_pkg::CountW-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;
  assign status_o    = status_q;
  assign count_o     = count_q;

endmodule

>>> rtl/bsal_checker.sv
// Port-level checker for the bounded shifting array list, bound to the top level.
`include "bounded_shifting_array_list_top_defines.svh"

module bsal_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [bsal_pkg::DataW-1:0]   read_data_o,
  input logic [1:0]                          status_o,
  input logic [bsal_pkg::CountW-1:0]         count_o
);

  `BSAL_ASSERT(a_accept_gives_result, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> out_valid_o)
  `BSAL_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(read_data_o) && $stable(status_o) && $stable(count_o)))
  `BSAL_ASSERT_MSG(a_err_no_data, clk_i, rst_ni, (out_valid_o && (status_o != bsal_pkg::ST_OK)) |-> (read_data_o == '0), "read data set on failed transaction")
  `BSAL_ASSERT_MSG(a_empty_count, clk_i, rst_ni, (out_valid_o && (status_o == bsal_pkg::ST_EMPTY)) |-> (count_o == '0), "empty status with nonzero count")

endmodule

bind bounded_shifting_array_list_top bsal_checker u_bsal_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .read_data_o (read_data_o),
  .status_o    (status_o),
  .count_o     (count_o)
);
